// ----- rtl/range_min_segment_tree_top_assert.svh -----
// ----------------------------------------------------------------------------
// Range-minimum segment tree: assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef RANGE_MIN_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_TOP_ASSERT_SVH

// same-cycle implication
`define RMST_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RMST_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rmst_pkg.sv -----
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared widths, codes and types of the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

   localparam int DW      = 32;   // node / value width
   localparam int IDX_W   = 11;   // position and query_high width
   localparam int CMD_W   = 2;
   localparam int CNT_W   = 11;   // leaf_count register width
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   localparam logic signed [DW-1:0] EMPTY_VAL        = 32'sh7FFF_FFFF;
   localparam logic [CNT_W-1:0]     LEAF_COUNT_RESET = 11'd1024;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INIT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

   // register index (paddr[2])
   localparam logic [0:0] REG_LEAF_COUNT = 1'b0;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_BUILD_RD,
      ST_BUILD_WR,
      ST_UP_RD,
      ST_UP_WR,
      ST_Q_RUN,
      ST_Q_OUT
   } state_type;

endpackage

// ----- rtl/rmst_csr.sv -----
// ----------------------------------------------------------------------------
// rmst_csr
// APB register file: holds leaf_count.
// ----------------------------------------------------------------------------
module rmst_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rmst_pkg::CSR_AW-1:0] paddr,
   input  logic [rmst_pkg::CSR_DW-1:0] pwdata,
   output logic [rmst_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output logic [rmst_pkg::CNT_W-1:0]  leaf_count
);
   import rmst_pkg::*;

   logic [CNT_W-1:0] leaf_count_ff, leaf_count_in;
   logic             wr_hit;

   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_LEAF_COUNT);

   always_comb begin
      leaf_count_in = leaf_count_ff;
      if (wr_hit) begin
         leaf_count_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaf_count_ff <= LEAF_COUNT_RESET;
      end else begin
         leaf_count_ff <= leaf_count_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_LEAF_COUNT) begin
         prdata = CSR_DW'(leaf_count_ff);
      end
   end

   assign pready     = 1'b1;
   assign leaf_count = leaf_count_ff;

endmodule

// ----- rtl/rmst_engine.sv -----
// ----------------------------------------------------------------------------
// rmst_engine
// Node memory plus sequencer: clear, init, leaf update, range query.
// ----------------------------------------------------------------------------
module rmst_engine #(
   parameter int LEAVES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rmst_pkg::CMD_W-1:0]    command,
   input  logic [rmst_pkg::IDX_W-1:0]    position,
   input  logic signed [rmst_pkg::DW-1:0] value,
   input  logic [rmst_pkg::IDX_W-1:0]    query_high,
   input  logic [rmst_pkg::CNT_W-1:0]    leaf_count,
   output logic                          rsp_valid,
   output logic signed [rmst_pkg::DW-1:0] rsp_min_value
);
   import rmst_pkg::*;

   localparam int LW    = $clog2(LEAVES);
   localparam int SPAN  = 1 << LW;
   localparam int AW    = LW + 1;          // node address
   localparam int CW    = AW + 1;          // query bounds reach 2*SPAN
   localparam int DEPTH = 1 << AW;
   localparam int IW    = (CW > IDX_W) ? CW : IDX_W;

   localparam logic [IW-1:0] LEAVES_X  = IW'(LEAVES);
   localparam logic [IW-1:0] SPAN_X    = IW'(SPAN);
   localparam logic [AW-1:0] ROOT      = AW'(1);
   localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);
   localparam logic [AW-1:0] SPAN_A    = AW'(SPAN);
   localparam logic [AW-1:0] INNER_TOP = AW'(SPAN - 1);

   // node memory, 1 write + 2 read ports, registered reads
   logic signed [DW-1:0] node_mem [0:DEPTH-1];
   logic                 we;
   logic [AW-1:0]        waddr, raddr0, raddr1;
   logic signed [DW-1:0] wdata;
   logic signed [DW-1:0] rd0_ff, rd1_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         node_mem[waddr] <= wdata;
      end
      rd0_ff <= node_mem[raddr0];
      rd1_ff <= node_mem[raddr1];
   end

   state_type            state_ff, state_in;
   logic [AW-1:0]        node_ff, node_in;
   logic [CW-1:0]        lo_ff, lo_in, up_ff, up_in;
   logic signed [DW-1:0] best_ff, best_in;
   logic                 take0_ff, take0_in, take1_ff, take1_in;

   logic                 accept, idle_like;
   logic [IW-1:0]        pos_x, hi_x, hi_clip, cnt_x, n_x, fill_i_x;
   logic                 q_empty, wr_ok;
   logic [AW-1:0]        wr_leaf, ch0, ch1;
   logic signed [DW-1:0] fill_val, pair_min, c0, c1, m01, acc;
   logic                 q_more, lo_odd, up_odd;
   logic [CW-1:0]        lo_nx, up_nx, up_m1;

   assign idle_like = (state_ff == ST_IDLE) || (state_ff == ST_Q_OUT);
   assign busy      = !idle_like;
   assign accept    = start && idle_like;

   // command decode
   assign pos_x   = IW'(position);
   assign hi_x    = IW'(query_high);
   assign hi_clip = (hi_x > LEAVES_X) ? LEAVES_X : hi_x;
   assign q_empty = !(pos_x < hi_clip);
   assign wr_ok   = pos_x < LEAVES_X;
   assign wr_leaf = AW'(pos_x + SPAN_X);

   // init leaf values
   assign cnt_x    = IW'(leaf_count);
   assign n_x      = (cnt_x > LEAVES_X) ? LEAVES_X : cnt_x;
   assign fill_i_x = IW'(node_ff[LW-1:0]);
   assign fill_val = (fill_i_x < n_x) ? DW'(fill_i_x + IW'(1)) : EMPTY_VAL;

   // inner node update
   assign ch0      = {node_ff[AW-2:0], 1'b0};
   assign ch1      = {node_ff[AW-2:0], 1'b1};
   assign pair_min = (rd0_ff < rd1_ff) ? rd0_ff : rd1_ff;

   // query walk
   assign q_more = lo_ff < up_ff;
   assign lo_odd = lo_ff[0];
   assign up_odd = up_ff[0];
   assign lo_nx  = (lo_ff + CW'(lo_odd)) >> 1;
   assign up_nx  = (up_ff - CW'(up_odd)) >> 1;
   assign up_m1  = up_ff - CW'(1);
   assign c0     = take0_ff ? rd0_ff : EMPTY_VAL;
   assign c1     = take1_ff ? rd1_ff : EMPTY_VAL;
   assign m01    = (c0 < c1) ? c0 : c1;
   assign acc    = (best_ff < m01) ? best_ff : m01;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (node_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE, ST_Q_OUT: begin
            state_in = ST_IDLE;
            if (accept) begin
               case (command)
                  CMD_INIT:  state_in = ST_FILL;
                  CMD_WRITE: state_in = wr_ok ? ST_UP_RD : ST_IDLE;
                  CMD_QUERY: state_in = q_empty ? ST_Q_OUT : ST_Q_RUN;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            if (node_ff == LAST_NODE) begin
               state_in = ST_BUILD_RD;
            end
         end
         ST_BUILD_RD: state_in = ST_BUILD_WR;
         ST_BUILD_WR: state_in = (node_ff == ROOT) ? ST_IDLE : ST_BUILD_RD;
         ST_UP_RD:    state_in = ST_UP_WR;
         ST_UP_WR:    state_in = (node_ff == ROOT) ? ST_IDLE : ST_UP_RD;
         ST_Q_RUN: begin
            if (!q_more) begin
               state_in = ST_Q_OUT;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory controls and result
   always_comb begin
      we     = 1'b0;
      waddr  = node_ff;
      wdata  = pair_min;
      raddr0 = ch0;
      raddr1 = ch1;
      case (state_ff)
         ST_CLEAR: begin
            we    = 1'b1;
            wdata = EMPTY_VAL;
         end
         ST_IDLE, ST_Q_OUT: begin
            if (accept && (command == CMD_WRITE) && wr_ok) begin
               we    = 1'b1;
               waddr = wr_leaf;
               wdata = value;
            end
         end
         ST_FILL: begin
            we    = 1'b1;
            wdata = fill_val;
         end
         ST_BUILD_WR, ST_UP_WR: begin
            we = 1'b1;
         end
         ST_Q_RUN: begin
            raddr0 = lo_ff[AW-1:0];
            raddr1 = up_m1[AW-1:0];
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   assign rsp_valid     = (state_ff == ST_Q_OUT);
   assign rsp_min_value = best_ff;

   // datapath next values
   always_comb begin
      node_in  = node_ff;
      lo_in    = lo_ff;
      up_in    = up_ff;
      best_in  = best_ff;
      take0_in = take0_ff;
      take1_in = take1_ff;
      case (state_ff)
         ST_CLEAR: node_in = node_ff + AW'(1);
         ST_IDLE, ST_Q_OUT: begin
            if (accept) begin
               case (command)
                  CMD_INIT:  node_in = SPAN_A;
                  CMD_WRITE: node_in = wr_leaf >> 1;
                  CMD_QUERY: begin
                     lo_in    = CW'(pos_x + SPAN_X);
                     up_in    = CW'(hi_clip + SPAN_X);
                     best_in  = EMPTY_VAL;
                     take0_in = 1'b0;
                     take1_in = 1'b0;
                  end
                  default: node_in = node_ff;
               endcase
            end
         end
         ST_FILL: node_in = (node_ff == LAST_NODE) ? INNER_TOP : node_ff + AW'(1);
         ST_BUILD_WR: node_in = node_ff - AW'(1);
         ST_UP_WR:    node_in = node_ff >> 1;
         ST_Q_RUN: begin
            best_in  = acc;   // fold in last cycle's reads
            take0_in = 1'b0;
            take1_in = 1'b0;
            if (q_more) begin
               lo_in    = lo_nx;
               up_in    = up_nx;
               take0_in = lo_odd;
               take1_in = up_odd;
            end
         end
         default: node_in = node_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         node_ff  <= '0;
         take0_ff <= 1'b0;
         take1_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         node_ff  <= node_in;
         take0_ff <= take0_in;
         take1_ff <= take1_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      up_ff   <= up_in;
      best_ff <= best_in;
   end

endmodule

// ----- rtl/range_min_segment_tree_top.sv -----
// ----------------------------------------------------------------------------
// range_min_segment_tree_top
// Range-minimum segment tree over LEAVES leaves, nodes kept in one RAM.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   -------------------------
//   request   req_command/position/value/         start && !busy
//             query_high
//   response  rsp_min_value                       rsp_valid, 1 cycle, no stall
//   config    psel penable pwrite paddr pwdata    APB, pready tied high
//             prdata pready
//
// SPAN = LEAVES rounded up to a power of two, L = log2(SPAN).
// After reset the node RAM is swept to the empty value, all 2*SPAN
// nodes, busy high throughout; csr writes still work.
// init: one leaf write per cycle, then read-pair / write-parent per
// inner node. write: the leaf is written at accept, then read-pair /
// write-parent on each level of the climb to the root.
// query: both RAM read ports are used per level. busy drops in the
// cycle the result word shows, so a new command can be taken then.
// The receiver never stalls.
// ----------------------------------------------------------------------------
`include "range_min_segment_tree_top_assert.svh"

module range_min_segment_tree_top #(
   parameter int LEAVES = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic [rmst_pkg::CMD_W-1:0]    req_command,
   input  logic [rmst_pkg::IDX_W-1:0]    req_position,
   input  logic signed [rmst_pkg::DW-1:0] req_value,
   input  logic [rmst_pkg::IDX_W-1:0]    req_query_high,
   // response
   output logic                          rsp_valid,
   output logic signed [rmst_pkg::DW-1:0] rsp_min_value,
   // config
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rmst_pkg::CSR_AW-1:0]   paddr,
   input  logic [rmst_pkg::CSR_DW-1:0]   pwdata,
   output logic [rmst_pkg::CSR_DW-1:0]   prdata,
   output logic                          pready
);
   import rmst_pkg::*;

   logic [CNT_W-1:0] leaf_count;

   // leaf_count register
   rmst_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .leaf_count (leaf_count)
   );

   // node RAM and command sequencer
   rmst_engine #(
      .LEAVES (LEAVES)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .command       (req_command),
      .position      (req_position),
      .value         (req_value),
      .query_high    (req_query_high),
      .leaf_count    (leaf_count),
      .rsp_valid     (rsp_valid),
      .rsp_min_value (rsp_min_value)
   );

   // ---- assertions ----
   // RAM sweep must follow reset
   `RMST_ASSERT_IMPLIES(a_clear_after_reset, $past(reset), busy, "no clear pass after reset")
   // init always occupies the engine
   `RMST_ASSERT_NEXT(a_init_busy, start && !busy && (req_command == CMD_INIT), busy,
      "init accepted but engine idle")
   // empty range answers at once with the empty value
   `RMST_ASSERT_NEXT(a_empty_query,
      start && !busy && (req_command == CMD_QUERY) && (req_position >= req_query_high),
      rsp_valid && (rsp_min_value == EMPTY_VAL), "empty range query result wrong")
   // csr write lands in leaf_count
   `RMST_ASSERT_NEXT(a_csr_write,
      psel && penable && pwrite && (paddr[2] == REG_LEAF_COUNT),
      leaf_count == $past(pwdata[CNT_W-1:0]), "leaf_count write lost")

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: range-minimum segment tree testbench
// Drives init / write / query command words into range_min_segment_tree_top,
// keeps its own min-tree alongside, and checks every min_value word.
// ----------------------------------------------------------------------------
module tb_top;
   import rmst_pkg::*;

   localparam int LEAVES      = 1024;
   localparam int SPAN        = 1 << $clog2(LEAVES);
   // longest silent stretch of the block is an init
   localparam int SETTLE      = 3 * SPAN + 64;
   localparam int QUIET_LIMIT = 20000;
   localparam int PHASES      = 6;
   localparam int PER_PHASE   = 255;
   localparam int PRINT_CAP   = 100;

   // command 3 is not decoded by the block
   localparam logic [CMD_W-1:0]  CMD_UNUSED      = 2'd3;
   // leaf_count is register 0 -> byte address 0
   localparam logic [CSR_AW-1:0] LEAF_COUNT_ADDR = {REG_LEAF_COUNT, 2'b00};

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic [IDX_W-1:0]        pos;
      logic signed [DW-1:0]    val;
      logic [IDX_W-1:0]        qhigh;
   } tree_cmd_type;

   // ---------------------------------------------------------------------
   // clock, reset, block inputs (all known from time zero)
   // ---------------------------------------------------------------------
   logic                    clock          = 1'b0;
   logic                    reset          = 1'b1;
   logic                    start          = 1'b0;
   logic [CMD_W-1:0]        req_command    = '0;
   logic [IDX_W-1:0]        req_position   = '0;
   logic signed [DW-1:0]    req_value      = '0;
   logic [IDX_W-1:0]        req_query_high = '0;
   logic                    psel           = 1'b0;
   logic                    penable        = 1'b0;
   logic                    pwrite         = 1'b0;
   logic [CSR_AW-1:0]       paddr          = '0;
   logic [CSR_DW-1:0]       pwdata         = '0;

   logic                    busy;
   logic                    rsp_valid;
   logic signed [DW-1:0]    rsp_min_value;
   logic [CSR_DW-1:0]       prdata;
   logic                    pready;

   always #10 clock = ~clock;

   range_min_segment_tree_top #(.LEAVES(LEAVES)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .req_query_high (req_query_high),
      .rsp_valid      (rsp_valid),
      .rsp_min_value  (rsp_min_value),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   // ---------------------------------------------------------------------
   // shared bookkeeping
   // ---------------------------------------------------------------------
   tree_cmd_type            pending_cmds[$];   // words waiting for the driver
   logic signed [DW-1:0]    expected_mins[$];  // min_value words still owed
   int                      words_queued  = 0;
   int                      words_taken   = 0;
   int                      results_seen  = 0;
   int                      csr_done      = 0;
   int                      errors        = 0;
   int                      sender_idle_pct = 0;

   // ---------------------------------------------------------------------
   // shadow min-tree: 1-based heap, node k has children 2k and 2k+1
   // ---------------------------------------------------------------------
   logic signed [DW-1:0]    tree_min[1:2*SPAN-1];
   logic [CNT_W-1:0]        leaf_limit = LEAF_COUNT_RESET;

   initial begin
      for (int k = 1; k < 2 * SPAN; k++) tree_min[k] = EMPTY_VAL;
   end

   function automatic logic signed [DW-1:0] lesser(logic signed [DW-1:0] a,
                                                   logic signed [DW-1:0] b);
      return (a < b) ? a : b;
   endfunction

   // leaves below the count get index+1, the rest go empty; a count
   // above LEAVES saturates, zero empties the whole tree
   function automatic void tree_init();
      int n;
      n = (int'(leaf_limit) > LEAVES) ? LEAVES : int'(leaf_limit);
      for (int i = 0; i < SPAN; i++)
         tree_min[SPAN + i] = (i < n) ? DW'(i + 1) : EMPTY_VAL;
      for (int k = SPAN - 1; k >= 1; k--)
         tree_min[k] = lesser(tree_min[2 * k], tree_min[2 * k + 1]);
   endfunction

   // out-of-range leaf is dropped silently
   function automatic void tree_write(int leaf, logic signed [DW-1:0] v);
      int p;
      if (leaf >= LEAVES) return;
      p = SPAN + leaf;
      tree_min[p] = v;
      while (p > 1) begin
         p = p >> 1;
         tree_min[p] = lesser(tree_min[2 * p], tree_min[2 * p + 1]);
      end
   endfunction

   // half-open [lo_leaf, hi_leaf), hi clipped to LEAVES, empty -> EMPTY_VAL
   function automatic logic signed [DW-1:0] tree_range_min(int lo_leaf, int hi_leaf);
      logic signed [DW-1:0] best;
      int lo;
      int up;
      best = EMPTY_VAL;
      if (hi_leaf > LEAVES) hi_leaf = LEAVES;
      if (lo_leaf < hi_leaf) begin
         lo = lo_leaf + SPAN;
         up = hi_leaf + SPAN;
         while (lo < up) begin
            if (lo % 2 == 1) begin
               best = lesser(best, tree_min[lo]);
               lo++;
            end
            if (up % 2 == 1) begin
               up--;
               best = lesser(best, tree_min[up]);
            end
            lo = lo >> 1;
            up = up >> 1;
         end
      end
      return best;
   endfunction

   // update the shadow tree for one accepted word; queries owe a result
   function automatic void apply_word(tree_cmd_type w);
      case (w.cmd)
         CMD_INIT:  tree_init();
         CMD_WRITE: tree_write(int'(w.pos), w.val);
         CMD_QUERY: expected_mins.push_back(tree_range_min(int'(w.pos), int'(w.qhigh)));
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, what);
      errors++;
   endtask

   // ---------------------------------------------------------------------
   // driver: a word is taken at the edge where start && !busy; the next
   // word (or a gap) is put up in that same edge, one NBA per signal
   // ---------------------------------------------------------------------
   tree_cmd_type on_port;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            apply_word(on_port);
            words_taken++;
         end
         if (!start || !busy) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               on_port = pending_cmds.pop_front();
               start          <= 1'b1;
               req_command    <= on_port.cmd;
               req_position   <= on_port.pos;
               req_value      <= on_port.val;
               req_query_high <= on_port.qhigh;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // monitor: rsp_valid is a one-cycle strobe, no back-pressure
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      logic signed [DW-1:0] want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_mins.size() == 0) begin
            report_mismatch($sformatf("min_value %0d with no query outstanding",
                                      rsp_min_value));
         end else begin
            want = expected_mins.pop_front();
            if (rsp_min_value !== want)
               report_mismatch($sformatf("min_value got %0d want %0d",
                                         rsp_min_value, want));
         end
      end
   end

   // ---------------------------------------------------------------------
   // watchdog: any accepted word (request, result, csr) counts as progress
   // ---------------------------------------------------------------------
   int quiet_cycles  = 0;
   int last_progress = 0;

   always @(posedge clock) begin : watchdog
      int progress;
      progress = words_taken + results_seen + csr_done;
      if (progress != last_progress) quiet_cycles = 0;
      else quiet_cycles++;
      last_progress = progress;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[%0t] timeout: no progress in %0d cycles", $realtime, QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // csr access: setup cycle, then access until pready
   // ---------------------------------------------------------------------
   task automatic csr_access(input logic wr, input logic [CSR_DW-1:0] data,
                             output logic [CSR_DW-1:0] rdata);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= LEAF_COUNT_ADDR;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (wr) leaf_limit = data[CNT_W-1:0];
      csr_done++;
   endtask

   // register keeps only its low CNT_W bits; read back and compare those
   task automatic leaf_count_readback();
      logic [CSR_DW-1:0] rd;
      csr_access(1'b0, '0, rd);
      if (rd[CNT_W-1:0] !== leaf_limit)
         report_mismatch($sformatf("leaf_count read %0d want %0d",
                                   rd[CNT_W-1:0], leaf_limit));
   endtask

   // ---------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_word(input logic [CMD_W-1:0] c, input int p,
                            input logic signed [DW-1:0] v, input int qh);
      tree_cmd_type w;
      w.cmd   = c;
      w.pos   = p[IDX_W-1:0];
      w.val   = v;
      w.qhigh = qh[IDX_W-1:0];
      pending_cmds.push_back(w);
      words_queued++;
   endtask

   // small values compete with the init ramp 1..leaf_count
   function automatic logic signed [DW-1:0] random_value();
      case ($urandom_range(0, 9))
         0:       return EMPTY_VAL;
         1:       return 32'sh8000_0000;
         2, 3:    return $urandom;
         default: return int'($urandom_range(0, 4000)) - 2000;
      endcase
   endfunction

   // mostly well-formed writes and queries; a little init and noise.
   // returns 1 when the word does anything at all
   task automatic push_random_word(output bit effective);
      int r;
      int lo;
      int hi;
      r = $urandom_range(0, 99);
      effective = 1'b1;
      if (r < 2) begin
         push_word(CMD_INIT, $urandom, $urandom, $urandom);
      end else if (r < 45) begin
         if ($urandom_range(0, 9) == 0) begin
            lo = $urandom_range(LEAVES, 2047);
            effective = 1'b0;
         end else begin
            lo = $urandom_range(0, LEAVES - 1);
         end
         push_word(CMD_WRITE, lo, random_value(), $urandom);
      end else if (r < 97) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               lo = $urandom_range(0, LEAVES - 1);
               hi = $urandom_range(lo + 1, LEAVES);
            end
            5, 6: begin
               lo = $urandom_range(0, LEAVES - 1);
               hi = lo + $urandom_range(1, 8);
            end
            default: begin
               lo = $urandom_range(0, 2047);
               hi = $urandom_range(0, 2047);
            end
         endcase
         push_word(CMD_QUERY, lo, $urandom, hi);
      end else begin
         push_word(CMD_UNUSED, $urandom, $urandom, $urandom);
         effective = 1'b0;
      end
   endtask

   // block is quiet: every request word taken, every result back, and
   // long enough after that for a trailing init or write to finish
   task automatic drain_and_settle();
      while (words_taken != words_queued || expected_mins.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int  lc_plan[PHASES];
      int  idle_plan[PHASES];
      int  made;
      bit  eff;
      logic [CSR_DW-1:0] rd;

      // phase 0 keeps the reset count; the rest sweep zero, one, the
      // register maximum, a random count and one past LEAVES
      lc_plan   = '{1024, 0, 1, 2047, -1, LEAVES + 1};
      idle_plan = '{0, 69, 10, 0, 69, 10};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset value visible while the node RAM is being cleared
      leaf_count_readback();

      // directed words, tree still all empty from the clearing pass
      push_word(CMD_QUERY, 0, $urandom, LEAVES);
      push_word(CMD_INIT, 0, 0, 0);
      push_word(CMD_QUERY, 0, 0, LEAVES);
      push_word(CMD_QUERY, LEAVES - 1, 0, LEAVES);
      push_word(CMD_QUERY, 0, 0, 0);                     // empty range at zero
      push_word(CMD_QUERY, 5, 0, 5);                     // empty range
      push_word(CMD_QUERY, 9, 0, 3);                     // reversed range
      push_word(CMD_QUERY, 1000, 0, 2047);               // end clipped to LEAVES
      push_word(CMD_QUERY, 2047, 0, 2047);               // start past the end
      push_word(CMD_WRITE, 0, 32'sh8000_0000, 2047);
      push_word(CMD_WRITE, LEAVES - 1, EMPTY_VAL, 0);
      push_word(CMD_WRITE, LEAVES, 7, 0);                // dropped
      push_word(CMD_WRITE, 2047, -5, 0);                 // dropped
      push_word(CMD_UNUSED, 3, EMPTY_VAL, 2047);         // no effect, no result
      push_word(CMD_QUERY, 0, 0, 2047);
      push_word(CMD_QUERY, 1, 0, LEAVES);
      push_word(CMD_QUERY, LEAVES - 2, 0, LEAVES);
      push_word(CMD_WRITE, 512, -1, 0);
      push_word(CMD_QUERY, 1, 0, LEAVES);
      push_word(CMD_WRITE, 513, 32'sh5555_5555, 1234);
      push_word(CMD_INIT, 2047, -1, 2047);               // unused fields all ones
      push_word(CMD_QUERY, 0, 0, LEAVES);

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            // pause: nothing in flight before touching the register
            drain_and_settle();
            if (lc_plan[p] < 0) lc_plan[p] = $urandom_range(2, LEAVES - 1);
            csr_access(1'b1, CSR_DW'({$urandom, CNT_W'(lc_plan[p])}), rd);
            leaf_count_readback();
            push_word(CMD_INIT, $urandom, $urandom, $urandom);
         end
         sender_idle_pct = idle_plan[p];
         made = 0;
         while (made < PER_PHASE) begin
            push_random_word(eff);
            if (eff) made++;
         end
      end

      drain_and_settle();

      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
